// ----- hdl/sib_pkg.sv -----
// ----------------------------------------------------------------------------
// sib_pkg
// Shared constants, codes and controller command type for the sorted
// insert buffer.
// ----------------------------------------------------------------------------
package sib_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int VALUE_W = 32;
    localparam int REJ_W   = 16;
    localparam int MODE_W  = 2;
    localparam int IM_W    = 3;
    localparam int CFG_W   = 5;

    localparam logic [REJ_W-1:0] REJ_MAX = '1;

    // item modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // insert modes
    localparam logic [IM_W-1:0] IM_APPEND   = 3'd0;
    localparam logic [IM_W-1:0] IM_SORTED   = 3'd1;
    localparam logic [IM_W-1:0] IM_PREPEND  = 3'd2;
    localparam logic [IM_W-1:0] IM_POS_ONLY = 3'd3;
    localparam logic [IM_W-1:0] IM_NEG_ONLY = 3'd4;

    // configuration register indexes
    localparam logic REG_INSERT_MODE = 1'b0;
    localparam logic REG_CAPACITY    = 1'b1;

    localparam logic [IM_W-1:0]  INSERT_MODE_RST = IM_SORTED;
    localparam logic [CNT_W-1:0] CAPACITY_RST    = 5'd16;

    typedef struct packed {
        logic load_item;
        logic compare;
        logic update;
        logic load_result;
    } ctrl_cmd_t;

endpackage

// ----- hdl/sib_ctrl.sv -----
// ----------------------------------------------------------------------------
// sib_ctrl
// Sequencer: accept, compare, update, result; owns the output valid flag.
// ----------------------------------------------------------------------------
module sib_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output sib_pkg::ctrl_cmd_t cmd
);
    import sib_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_RES  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   res_free;

    assign res_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_RES;
            end
            S_RES:
            begin
                // hold here while the previous transaction is still unclaimed
                if (res_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hdl/sib_datapath.sv -----
// ----------------------------------------------------------------------------
// sib_datapath
// Slot store with valid bits, config registers, sign-reject counter,
// parallel compare, insert/shift update and result register.
// ----------------------------------------------------------------------------
module sib_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sib_pkg::ctrl_cmd_t                     cmd,
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_index,
    input  logic [sib_pkg::CFG_W-1:0]              cfg_data,
    input  logic [sib_pkg::MODE_W-1:0]             mode,
    input  logic signed [sib_pkg::VALUE_W-1:0]     value,
    input  logic [sib_pkg::IDX_W-1:0]              read_index,
    output logic                                   accepted,
    output logic                                   dropped_full,
    output logic                                   rejected_sign,
    output logic [sib_pkg::CNT_W-1:0]              stored_count,
    output logic signed [sib_pkg::VALUE_W-1:0]     read_value,
    output logic                                   read_valid,
    output logic [sib_pkg::REJ_W-1:0]              rejected_total
);
    import sib_pkg::*;

    // configuration
    logic [IM_W-1:0]  insert_mode_reg;
    logic [CNT_W-1:0] capacity_reg;

    // latched item
    logic [MODE_W-1:0]         mode_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [IDX_W-1:0]          ridx_reg;

    // store
    logic [VALUE_W-1:0] entries_reg  [DEPTH];
    logic [VALUE_W-1:0] entries_next [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    logic [REJ_W-1:0]   rej_cnt_reg;
    logic [REJ_W-1:0]   rej_cnt_next;

    logic [DEPTH-1:0] lt_reg;
    logic [DEPTH-1:0] lt_next;
    logic             acc_reg, drop_reg, rej_reg;
    logic             acc_next, drop_next, rej_next;

    // derived
    logic [CNT_W-1:0] cap_m1;
    logic [IDX_W-1:0] last_idx;
    logic [DEPTH-1:0] use_mask;
    logic [DEPTH-1:0] free_mask;
    logic [IDX_W-1:0] app_slot;
    logic [IDX_W-1:0] pre_slot;
    logic [CNT_W-1:0] pos;
    logic             wrong_sign;
    logic [CNT_W-1:0] count;

    // result register
    logic                      accepted_reg, dropped_full_reg, rejected_sign_reg;
    logic [CNT_W-1:0]          stored_count_reg;
    logic signed [VALUE_W-1:0] read_value_reg;
    logic                      read_valid_reg;
    logic [REJ_W-1:0]          rejected_total_reg;

    // capacity clamp: 0 acts as 1, above DEPTH acts as DEPTH
    assign cap_m1 = capacity_reg - CNT_W'(1);
    always_comb
    begin
        if (capacity_reg == '0)
            last_idx = '0;
        else if (capacity_reg > CNT_W'(DEPTH))
            last_idx = IDX_W'(DEPTH - 1);
        else
            last_idx = cap_m1[IDX_W-1:0];
    end

    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            use_mask[j] = (IDX_W'(j) <= last_idx);
            lt_next[j]  = valid_reg[j] && use_mask[j] &&
                          ($signed(entries_reg[j]) < value_reg);
        end
    end

    assign free_mask = ~valid_reg & use_mask;

    // lowest free, highest free, insert position above last smaller entry
    always_comb
    begin
        app_slot = '0;
        pre_slot = '0;
        pos      = '0;
        for (int j = DEPTH - 1; j >= 0; j--)
            if (free_mask[j])
                app_slot = IDX_W'(j);
        for (int j = 0; j < DEPTH; j++)
        begin
            if (free_mask[j])
                pre_slot = IDX_W'(j);
            if (lt_reg[j])
                pos = CNT_W'(j + 1);
        end
    end

    assign wrong_sign = ((insert_mode_reg == IM_POS_ONLY) &&
                         !(value_reg > 0)) ||
                        ((insert_mode_reg == IM_NEG_ONLY) &&
                         !(value_reg < 0));

    always_comb
    begin
        entries_next = entries_reg;
        valid_next   = valid_reg;
        rej_cnt_next = rej_cnt_reg;
        acc_next     = 1'b0;
        drop_next    = 1'b0;
        rej_next     = 1'b0;
        case (mode_reg)
            MODE_INSERT:
            begin
                if (wrong_sign)
                begin
                    rej_next = 1'b1;
                    if (rej_cnt_reg != REJ_MAX)
                        rej_cnt_next = rej_cnt_reg + REJ_W'(1);
                end
                else
                begin
                    case (insert_mode_reg)
                        IM_APPEND, IM_PREPEND:
                        begin
                            if (|free_mask)
                            begin
                                acc_next = 1'b1;
                                if (insert_mode_reg == IM_APPEND)
                                begin
                                    entries_next[app_slot] = value_reg;
                                    valid_next[app_slot]   = 1'b1;
                                end
                                else
                                begin
                                    entries_next[pre_slot] = value_reg;
                                    valid_next[pre_slot]   = 1'b1;
                                end
                            end
                            else
                                drop_next = 1'b1;
                        end
                        default:
                        begin
                            if (!valid_reg[0])
                            begin
                                entries_next[0] = value_reg;
                                valid_next[0]   = 1'b1;
                                acc_next        = 1'b1;
                            end
                            else if (valid_reg[last_idx])
                                drop_next = 1'b1;
                            else
                            begin
                                acc_next = 1'b1;
                                // slots above pos move up one, within use
                                for (int j = 1; j < DEPTH; j++)
                                begin
                                    if ((CNT_W'(j) > pos) && (IDX_W'(j) <= last_idx))
                                    begin
                                        entries_next[j] = entries_reg[j-1];
                                        valid_next[j]   = valid_reg[j-1];
                                    end
                                end
                                for (int j = 0; j < DEPTH; j++)
                                begin
                                    if (CNT_W'(j) == pos)
                                    begin
                                        entries_next[j] = value_reg;
                                        valid_next[j]   = 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            MODE_CLEAR:
            begin
                valid_next   = '0;
                rej_cnt_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        count = '0;
        for (int j = 0; j < DEPTH; j++)
            count = count + CNT_W'(valid_reg[j] & use_mask[j]);
    end

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insert_mode_reg <= INSERT_MODE_RST;
            capacity_reg    <= CAPACITY_RST;
            valid_reg       <= '0;
            rej_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_INSERT_MODE)
                    insert_mode_reg <= cfg_data[IM_W-1:0];
                else
                    capacity_reg <= cfg_data[CNT_W-1:0];
            end
            if (cmd.update)
            begin
                valid_reg   <= valid_next;
                rej_cnt_reg <= rej_cnt_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg  <= mode;
            value_reg <= value;
            ridx_reg  <= read_index;
        end
        if (cmd.compare)
            lt_reg <= lt_next;
        if (cmd.update)
        begin
            entries_reg <= entries_next;
            acc_reg     <= acc_next;
            drop_reg    <= drop_next;
            rej_reg     <= rej_next;
        end
        if (cmd.load_result)
        begin
            accepted_reg       <= acc_reg;
            dropped_full_reg   <= drop_reg;
            rejected_sign_reg  <= rej_reg;
            stored_count_reg   <= count;
            rejected_total_reg <= rej_cnt_reg;
            if ((mode_reg == MODE_READ) && (ridx_reg <= last_idx) && valid_reg[ridx_reg])
            begin
                read_value_reg <= entries_reg[ridx_reg];
                read_valid_reg <= 1'b1;
            end
            else
            begin
                read_value_reg <= '0;
                read_valid_reg <= 1'b0;
            end
        end
    end

    assign accepted       = accepted_reg;
    assign dropped_full   = dropped_full_reg;
    assign rejected_sign  = rejected_sign_reg;
    assign stored_count   = stored_count_reg;
    assign read_value     = read_value_reg;
    assign read_valid     = read_valid_reg;
    assign rejected_total = rejected_total_reg;

endmodule

// ----- hdl/sorted_insert_buffer_top.sv -----
// A transaction is taken in idle, then runs the sequencer's compare,
//   update and result steps over the single slot store before the next
//   is taken; the result step loads the output register.
// The result step waits while an earlier result is still stalled.
// Reset (rst_n low, async): slots empty, reject counter zero, insert mode
//   sorted, capacity 16; slot data is not cleared.
// ----------------------------------------------------------------------------
// sorted_insert_buffer_top
// Fixed store of signed Q16.16 values kept in append, prepend or ascending
// order, with sign filtering, full detection, read and clear.
// ----------------------------------------------------------------------------
module sorted_insert_buffer_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [sib_pkg::CFG_W-1:0]          cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sib_pkg::MODE_W-1:0]         mode,
    input  logic signed [sib_pkg::VALUE_W-1:0] value,
    input  logic [sib_pkg::IDX_W-1:0]          read_index,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               accepted,
    output logic                               dropped_full,
    output logic                               rejected_sign,
    output logic [sib_pkg::CNT_W-1:0]          stored_count,
    output logic signed [sib_pkg::VALUE_W-1:0] read_value,
    output logic                               read_valid,
    output logic [sib_pkg::REJ_W-1:0]          rejected_total
);
    import sib_pkg::*;

    // step commands from the sequencer to the datapath
    ctrl_cmd_t cmd;

    // Sequencer: takes one transaction in idle, then walks compare ->
    // update -> result. Input is stalled outside idle.
    sib_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath: the compare step registers a less-than vector over all
    // slots; the update step places the value (lowest free, highest free,
    // or above the last smaller entry with the rest shifted up) and keeps
    // the saturating reject counter; the result step counts occupied slots
    // in use and reads the requested slot into the output register.
    sib_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .value          (value),
        .read_index     (read_index),
        .accepted       (accepted),
        .dropped_full   (dropped_full),
        .rejected_sign  (rejected_sign),
        .stored_count   (stored_count),
        .read_value     (read_value),
        .read_valid     (read_valid),
        .rejected_total (rejected_total)
    );

endmodule

// ----- tb/sv/tb_sorted_insert_buffer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_insert_buffer_top
// Self-checking bench for the sorted insert buffer. A class holds a shadow
// copy of the slot store and predicts the status of every transaction taken
// on the input channel. Results are compared in order as they leave the
// output channel. Stimulus is a directed opening, randomized phases over all
// insert modes and a range of capacities, and a burst of sign-rejected inserts.
// ----------------------------------------------------------------------------
import sib_pkg::*;

typedef struct packed {
    logic [MODE_W-1:0]  op;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   slot;
} store_cmd_t;

typedef struct packed {
    logic                      accepted;
    logic                      dropped_full;
    logic                      rejected_sign;
    logic [CNT_W-1:0]          stored_count;
    logic signed [VALUE_W-1:0] read_value;
    logic                      read_valid;
    logic [REJ_W-1:0]          rejected_total;
} store_status_t;

class slot_store_checker;
    logic signed [VALUE_W-1:0] slot_val [DEPTH];
    logic [DEPTH-1:0]          slot_used;
    logic [REJ_W-1:0]          sign_rejects;
    logic [IM_W-1:0]           insert_mode;
    logic [CNT_W-1:0]          capacity;
    store_status_t             expected_status [$];
    int unsigned               error_count;

    function new();
        foreach (slot_val[i])
            slot_val[i] = '0;
        slot_used    = '0;
        sign_rejects = '0;
        insert_mode  = INSERT_MODE_RST;
        capacity     = CAPACITY_RST;
        error_count  = 0;
    endfunction

    function void write_register(logic sel, logic [CFG_W-1:0] data);
        if (sel == REG_INSERT_MODE)
            insert_mode = data[IM_W-1:0];
        else
            capacity = data;
    endfunction

    function int pending();
        return expected_status.size();
    endfunction

    // capacity 0 behaves as 1, anything past the built depth as the depth
    function int slots_active();
        if (capacity == 0)
            return 1;
        if (capacity > DEPTH)
            return DEPTH;
        return int'(capacity);
    endfunction

    // first free slot from the bottom (append) or from the top (prepend)
    function bit free_slot_place(logic signed [VALUE_W-1:0] v, int n, bit from_top);
        int slot;
        slot = -1;
        for (int i = 0; i < n; i++)
        begin
            if (from_top && !slot_used[n-1-i] && slot < 0)
                slot = n - 1 - i;
            else if (!from_top && !slot_used[i] && slot < 0)
                slot = i;
        end
        if (slot < 0)
            return 1'b0;
        slot_val[slot]  = v;
        slot_used[slot] = 1'b1;
        return 1'b1;
    endfunction

    // ascending insert; equal values land below existing ones
    function bit sorted_place(logic signed [VALUE_W-1:0] v, int n);
        int pos;
        pos = 0;
        if (!slot_used[0])
        begin
            slot_val[0]  = v;
            slot_used[0] = 1'b1;
            return 1'b1;
        end
        if (slot_used[n-1])
            return 1'b0;
        for (int i = n - 1; i >= 0; i--)
        begin
            if (slot_used[i] && slot_val[i] < v)
            begin
                pos = i + 1;
                break;
            end
        end
        for (int i = n - 2; i >= pos; i--)
        begin
            slot_val[i+1]  = slot_val[i];
            slot_used[i+1] = slot_used[i];
        end
        slot_val[pos]  = v;
        slot_used[pos] = 1'b1;
        return 1'b1;
    endfunction

    function store_status_t predict_status(store_cmd_t c);
        store_status_t             r;
        int                        n;
        logic signed [VALUE_W-1:0] v;
        bit                        wrong_sign;
        bit                        stored;
        r = '0;
        n = slots_active();
        v = c.value;
        case (c.op)
            MODE_INSERT:
            begin
                wrong_sign = (insert_mode == IM_POS_ONLY && !(v > 0)) ||
                             (insert_mode == IM_NEG_ONLY && !(v < 0));
                if (wrong_sign)
                begin
                    r.rejected_sign = 1'b1;
                    if (sign_rejects != REJ_MAX)
                        sign_rejects = sign_rejects + 1'b1;
                end
                else
                begin
                    if (insert_mode == IM_APPEND || insert_mode == IM_PREPEND)
                        stored = free_slot_place(v, n, insert_mode == IM_PREPEND);
                    else
                        stored = sorted_place(v, n);
                    r.accepted     = stored;
                    r.dropped_full = !stored;
                end
            end
            MODE_READ:
            begin
                if (c.slot < n && slot_used[c.slot])
                begin
                    r.read_value = slot_val[c.slot];
                    r.read_valid = 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                slot_used    = '0;
                sign_rejects = '0;
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++)
            if (slot_used[i])
                r.stored_count = r.stored_count + 1'b1;
        r.rejected_total = sign_rejects;
        return r;
    endfunction

    function void note_transaction(store_cmd_t c);
        expected_status.push_back(predict_status(c));
    endfunction

    function void compare_field(string name, logic [VALUE_W-1:0] want,
                                logic [VALUE_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            // keep the log bounded if the block is badly broken
            if (error_count <= 200)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endfunction

    function void check_transaction(store_status_t got);
        store_status_t want;
        if (expected_status.size() == 0)
        begin
            error_count++;
            if (error_count <= 200)
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
        end
        want = expected_status.pop_front();
        compare_field("accepted", VALUE_W'(want.accepted), VALUE_W'(got.accepted));
        compare_field("dropped_full", VALUE_W'(want.dropped_full),
                      VALUE_W'(got.dropped_full));
        compare_field("rejected_sign", VALUE_W'(want.rejected_sign),
                      VALUE_W'(got.rejected_sign));
        compare_field("stored_count", VALUE_W'(want.stored_count),
                      VALUE_W'(got.stored_count));
        compare_field("read_value", want.read_value, got.read_value);
        compare_field("read_valid", VALUE_W'(want.read_valid), VALUE_W'(got.read_valid));
        compare_field("rejected_total", VALUE_W'(want.rejected_total),
                      VALUE_W'(got.rejected_total));
    endfunction
endclass

module tb_sorted_insert_buffer_top;

    // item mode 3 has no function in the block: status only
    localparam logic [MODE_W-1:0] MODE_STATUS = 2'd3;
    // undefined insert modes, expected to behave as sorted
    localparam logic [IM_W-1:0]   IM_SPARE_5  = 3'd5;
    localparam logic [IM_W-1:0]   IM_SPARE_6  = 3'd6;
    localparam logic [IM_W-1:0]   IM_SPARE_7  = 3'd7;

    localparam int     CLK_PERIOD    = 10;
    localparam int     IDLE_PCT      = 29;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     RANDOM_PHASES = 18;
    localparam int     PHASE_ITEMS   = 84;
    // rejected inserts in the closing burst
    localparam int     REJ_ITEMS     = 16;
    // watchdog limit for ~1550 transactions plus random gaps and one long hold-off
    localparam longint CYCLE_LIMIT   = 200000;

    // per-phase insert mode and capacity; capacities sweep 0, 1, 2, 3, 5, 8, 12,
    // 16 and the out-of-range values 17 and 31 above the depth
    localparam logic [IM_W-1:0] PHASE_MODES [RANDOM_PHASES] = '{
        IM_SORTED, IM_APPEND, IM_POS_ONLY, IM_NEG_ONLY, IM_PREPEND, IM_SORTED,
        IM_SPARE_5, IM_POS_ONLY, IM_SORTED, IM_APPEND, IM_NEG_ONLY, IM_SPARE_7,
        IM_PREPEND, IM_SORTED, IM_SPARE_6, IM_NEG_ONLY, IM_POS_ONLY, IM_APPEND
    };
    localparam logic [CFG_W-1:0] PHASE_CAPS [RANDOM_PHASES] = '{
        5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd12, 5'd31, 5'd16,
        5'd0, 5'd16, 5'd17, 5'd1, 5'd2, 5'd8, 5'd5, 5'd3, 5'd16
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic                      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          read_index;
    logic                      out_valid;
    logic                      out_stall;
    logic                      accepted;
    logic                      dropped_full;
    logic                      rejected_sign;
    logic [CNT_W-1:0]          stored_count;
    logic signed [VALUE_W-1:0] read_value;
    logic                      read_valid;
    logic [REJ_W-1:0]          rejected_total;

    // knobs shared between the sender, the receiver and the main sequence
    int              tx_idle_pct     = IDLE_PCT;
    int              rx_idle_pct     = IDLE_PCT;
    int              rx_hold_cycles  = 0;
    logic [IM_W-1:0] cur_insert_mode = INSERT_MODE_RST;
    longint          cycle_count     = 0;

    slot_store_checker store_check = new();

    sorted_insert_buffer_top DUT (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the edge, before any NBA update,
    // so a transaction is seen exactly when the block takes it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                store_check.note_transaction(store_cmd_t'({mode, value, read_index}));
            if (out_valid && !out_stall)
                store_check.check_transaction(store_status_t'({accepted, dropped_full,
                    rejected_sign, stored_count, read_value, read_valid,
                    rejected_total}));
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, plus a long hold-off on request. The hold
    // is counted here so the sender keeps pushing while the output backs up.
    // ------------------------------------------------------------------
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offer one transaction, with an optional random gap in front of it.
    // Valid is only dropped during a gap, so back-to-back items keep it high.
    task automatic send_item(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] v,
                             input logic [IDX_W-1:0] slot);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        value      <= v;
        read_index <= slot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait until every predicted status has come back.
    // The first edge lets the monitor log the last transaction taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (store_check.pending() != 0)
            @(posedge clk);
    endtask

    // Both registers, written back to back on an idle block. The unused
    // upper bits of the insert mode write carry random junk.
    task automatic set_config(input logic [IM_W-1:0] im, input logic [CFG_W-1:0] cap);
        logic [CFG_W-1:0] im_word;
        im_word = CFG_W'({$urandom_range(3), im});
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_INSERT_MODE;
        cfg_data  <= im_word;
        store_check.write_register(REG_INSERT_MODE, im_word);
        @(posedge clk);
        cfg_index <= REG_CAPACITY;
        cfg_data  <= cap;
        store_check.write_register(REG_CAPACITY, cap);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_insert_mode = im;
    endtask

    // Values: extremes, small Q16.16 integers (to force equal keys), +/-1 lsb,
    // and full-range random.
    function automatic logic [VALUE_W-1:0] pick_value();
        int k;
        k = int'($urandom_range(6)) - 3;
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4:    return VALUE_W'(k * 65536);
            5:       return $urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Mostly inserts and reads; clears are rare so the store regularly fills.
    // In the sign-filtered modes three of four inserts carry the passing sign.
    function automatic store_cmd_t random_item();
        store_cmd_t c;
        int         pick;
        pick    = $urandom_range(99);
        c.value = pick_value();
        c.slot  = IDX_W'($urandom_range(DEPTH - 1));
        if (pick < 62)
            c.op = MODE_INSERT;
        else if (pick < 94)
            c.op = MODE_READ;
        else if (pick < 98)
            c.op = MODE_STATUS;
        else
            c.op = MODE_CLEAR;
        if ($urandom_range(3) != 0)
        begin
            if (cur_insert_mode == IM_POS_ONLY)
            begin
                c.value[VALUE_W-1] = 1'b0;
                if (c.value == '0)
                    c.value = 32'h0000_0001;
            end
            else if (cur_insert_mode == IM_NEG_ONLY)
                c.value[VALUE_W-1] = 1'b1;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        store_cmd_t c;
        rst_n      <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= REG_INSERT_MODE;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        mode       <= MODE_INSERT;
        value      <= '0;
        read_index <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: reset config is sorted, capacity 16 ---
        send_item(MODE_INSERT, 32'h0000_0000, 4'd0);   // empty store, straight to slot 0
        send_item(MODE_INSERT, 32'h7FFF_FFFF, 4'd15);
        send_item(MODE_INSERT, 32'h8000_0000, 4'd0);   // smallest, shifts all up
        send_item(MODE_INSERT, 32'h0000_0000, 4'd7);   // equal key goes below
        send_item(MODE_INSERT, 32'h0001_8000, 4'd3);
        send_item(MODE_READ,   32'hFFFF_FFFF, 4'd0);
        send_item(MODE_READ,   32'h0000_0000, 4'd1);
        send_item(MODE_READ,   32'h1234_5678, 4'd15);  // empty slot
        send_item(MODE_STATUS, 32'hA5A5_A5A5, 4'd9);
        send_item(MODE_CLEAR,  32'h5A5A_5A5A, 4'd6);

        // sign filters: zero is rejected by both
        set_config(IM_POS_ONLY, 5'd16);
        send_item(MODE_INSERT, 32'h0000_0000, 4'd0);
        send_item(MODE_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_item(MODE_INSERT, 32'h0000_0001, 4'd0);
        set_config(IM_NEG_ONLY, 5'd16);
        send_item(MODE_INSERT, 32'h0000_0000, 4'd0);
        send_item(MODE_INSERT, 32'h7FFF_FFFF, 4'd0);
        send_item(MODE_INSERT, 32'h8000_0000, 4'd0);
        send_item(MODE_READ,   32'h0000_0000, 4'd1);

        // capacity 0 acts as 1: slot 0 already holds a value, slot 1 hidden
        set_config(IM_APPEND, 5'd0);
        send_item(MODE_INSERT, 32'h0002_0000, 4'd0);
        send_item(MODE_READ,   32'h0000_0000, 4'd1);
        send_item(MODE_STATUS, 32'h0000_0000, 4'd0);

        // prepend fills from the top of the in-use range
        set_config(IM_PREPEND, 5'd16);
        send_item(MODE_INSERT, 32'hFFFE_8000, 4'd0);
        send_item(MODE_READ,   32'h0000_0000, 4'd15);

        // --- random phases; capacity changes keep the slot contents ---
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_config(PHASE_MODES[p], PHASE_CAPS[p]);
            tx_idle_pct = (p == 8 || p == 9) ? 0 : IDLE_PCT;
            rx_idle_pct = (p == 8 || p == 9) ? 0 : IDLE_PCT;
            if (p == 5)
            begin
                // back up the output while the sender keeps going
                tx_idle_pct    = 0;
                rx_hold_cycles = HOLD_CYCLES;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                c = random_item();
                send_item(c.op, c.value, c.slot);
            end
        end

        // --- burst of sign rejects: non-negative values in negative-only
        // mode, run at full rate ---
        set_config(IM_NEG_ONLY, 5'd16);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(MODE_CLEAR, 32'h0000_0000, 4'd0);
        for (int k = 0; k < REJ_ITEMS; k++)
            send_item(MODE_INSERT, {1'b0, 31'($urandom)}, IDX_W'($urandom_range(DEPTH - 1)));
        send_item(MODE_STATUS, 32'h0000_0000, 4'd0);
        send_item(MODE_CLEAR,  32'h0000_0000, 4'd0);
        send_item(MODE_INSERT, 32'h0000_0000, 4'd0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (store_check.error_count == 0 && store_check.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
